### rtl/slcd_pkg.sv
package slcd_pkg;

   // Line storage limits.
   localparam int LINE_CAPACITY = 256;
   localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
   localparam int HEAD_DEPTH = 7;
   localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);
   localparam int RESP_DEPTH = 9;
   localparam int RESP_CNT_W = $clog2(RESP_DEPTH + 1);

   // Character codes.
   localparam logic [7:0] CHAR_DEL = 8'h7F;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_SP = 8'h20;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef logic [HEAD_DEPTH-1:0][7:0] head_type;
   typedef logic [RESP_DEPTH-1:0][7:0] resp_type;

   // Command texts, first character in element 0, padded with NUL.
   localparam head_type CMD_ON = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "n", "o"};
   localparam head_type CMD_F = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "f"};
   localparam head_type CMD_OFF = {8'h00, 8'h00, 8'h00, 8'h00, "f", "f", "o"};
   localparam head_type CMD_TOGGLE = {8'h00, "e", "l", "g", "g", "o", "t"};

   // Compared lengths include the terminating NUL.
   localparam logic [2:0] SIZE_ON = 3'd3;
   localparam logic [2:0] SIZE_F = 3'd2;
   localparam logic [2:0] SIZE_OFF = 3'd4;
   localparam logic [2:0] SIZE_TOGGLE = 3'd7;

   // Fold upper-case letters to lower case.
   function automatic logic [7:0] fold_char(logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // Bounded compare of the folded line against a command; a NUL in the
   // line that lines up with the command end stops the compare with a hit.
   function automatic logic cmd_match(head_type head, logic [LEN_W-1:0] len,
                                      head_type pat, logic [2:0] patsize);
      logic       res;
      logic       done;
      logic [7:0] b;
      res = (len != '0);
      done = (len == '0);
      b = CHAR_NUL;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (!done && LEN_W'(i) < len && 3'(i) < patsize) begin
            b = fold_char(head[i]);
            if (b != pat[i]) begin
               res = 1'b0;
               done = 1'b1;
            end else if (b == CHAR_NUL) begin
               done = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

### rtl/serial_line_command_decoder_unit.sv
// Serial line command decoder. Each received byte edits a command line
// (DEL removes the last character of a nonempty line, other bytes are kept
// up to the line capacity) and, with echo enabled, is echoed back; CR runs
// the line as a command (prefixes of "on", "f"/"off", "toggle") and answers
// OK or ERROR followed by CR LF. An accepted byte waits in the input
// register and is decoded into the result buffer, which then sends its
// zero to nine reply words one per cycle while rsp_stall is low. The
// input register takes the next byte while the buffer still drains, so
// the byte rate is set by the reply length and by rsp_stall. rsp_last_byte
// marks the final word of each reply, and rsp_led_on shows the LED level
// after the byte that caused the word.
module serial_line_command_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_byte,
   output logic       rsp_led_on
);

   logic                               echo_ff;
   logic                               in_valid_ff, in_valid_in;
   logic [7:0]                         in_byte_ff;
   logic [slcd_pkg::LEN_W-1:0]         len_ff, len_in;
   slcd_pkg::head_type                 head_ff;
   logic                               led_ff, led_in;
   slcd_pkg::resp_type                 resp_ff, resp_in;
   logic [slcd_pkg::RESP_CNT_W-1:0]    cnt_ff, cnt_in;

   logic out_free;
   logic load;
   logic is_cr;
   logic is_del;
   logic del_hit;
   logic store;
   logic hit_on, hit_off, hit_toggle, cmd_ok;
   slcd_pkg::resp_type                 new_resp;
   logic [slcd_pkg::RESP_CNT_W-1:0]    new_cnt;

   // Buffer is free when empty or when its last word leaves this cycle.
   assign out_free = (cnt_ff == '0) ||
                     (cnt_ff == slcd_pkg::RESP_CNT_W'(1) && !rsp_stall);
   assign load = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !load);

   // Line editing decisions for the held byte.
   assign is_cr = (in_byte_ff == slcd_pkg::CHAR_CR);
   assign is_del = (in_byte_ff == slcd_pkg::CHAR_DEL);
   assign del_hit = is_del && (len_ff != '0);
   assign store = !del_hit && !is_cr &&
                  (len_ff < slcd_pkg::LEN_W'(slcd_pkg::LINE_CAPACITY));

   // Command matching, first hit in order on, off, toggle.
   assign hit_on = slcd_pkg::cmd_match(head_ff, len_ff, slcd_pkg::CMD_ON,
                                       slcd_pkg::SIZE_ON);
   assign hit_off = slcd_pkg::cmd_match(head_ff, len_ff, slcd_pkg::CMD_F,
                                        slcd_pkg::SIZE_F) ||
                    slcd_pkg::cmd_match(head_ff, len_ff, slcd_pkg::CMD_OFF,
                                        slcd_pkg::SIZE_OFF);
   assign hit_toggle = slcd_pkg::cmd_match(head_ff, len_ff, slcd_pkg::CMD_TOGGLE,
                                           slcd_pkg::SIZE_TOGGLE);
   assign cmd_ok = hit_on || hit_off || hit_toggle;

   // Next line length and LED level.
   always_comb begin
      len_in = len_ff;
      led_in = led_ff;
      if (load) begin
         priority if (is_cr) begin
            len_in = '0;
            priority if (hit_on) begin
               led_in = 1'b1;
            end else if (hit_off) begin
               led_in = 1'b0;
            end else if (hit_toggle) begin
               led_in = !led_ff;
            end else begin
               led_in = led_ff;
            end
         end else if (del_hit) begin
            len_in = len_ff - slcd_pkg::LEN_W'(1);
         end else if (store) begin
            len_in = len_ff + slcd_pkg::LEN_W'(1);
         end else begin
            len_in = len_ff;
         end
      end
   end

   // Reply words for the held byte: echo first, then the command answer.
   always_comb begin
      new_resp = '0;
      new_cnt = '0;
      if (is_cr) begin
         if (echo_ff) begin
            new_resp[0] = slcd_pkg::CHAR_CR;
            new_resp[1] = slcd_pkg::CHAR_LF;
            if (cmd_ok) begin
               new_resp[2] = "O";
               new_resp[3] = "K";
               new_resp[4] = slcd_pkg::CHAR_CR;
               new_resp[5] = slcd_pkg::CHAR_LF;
               new_cnt = slcd_pkg::RESP_CNT_W'(6);
            end else begin
               new_resp[2] = "E";
               new_resp[3] = "R";
               new_resp[4] = "R";
               new_resp[5] = "O";
               new_resp[6] = "R";
               new_resp[7] = slcd_pkg::CHAR_CR;
               new_resp[8] = slcd_pkg::CHAR_LF;
               new_cnt = slcd_pkg::RESP_CNT_W'(9);
            end
         end else if (cmd_ok) begin
            new_resp[0] = "O";
            new_resp[1] = "K";
            new_resp[2] = slcd_pkg::CHAR_CR;
            new_resp[3] = slcd_pkg::CHAR_LF;
            new_cnt = slcd_pkg::RESP_CNT_W'(4);
         end else begin
            new_resp[0] = "E";
            new_resp[1] = "R";
            new_resp[2] = "R";
            new_resp[3] = "O";
            new_resp[4] = "R";
            new_resp[5] = slcd_pkg::CHAR_CR;
            new_resp[6] = slcd_pkg::CHAR_LF;
            new_cnt = slcd_pkg::RESP_CNT_W'(7);
         end
      end else if (echo_ff) begin
         if (del_hit) begin
            new_resp[0] = slcd_pkg::CHAR_BS;
            new_resp[1] = slcd_pkg::CHAR_SP;
            new_resp[2] = slcd_pkg::CHAR_BS;
            new_cnt = slcd_pkg::RESP_CNT_W'(3);
         end else begin
            new_resp[0] = in_byte_ff;
            new_cnt = slcd_pkg::RESP_CNT_W'(1);
         end
      end
   end

   // Result buffer: load a new reply or shift out the word just taken.
   always_comb begin
      resp_in = resp_ff;
      cnt_in = cnt_ff;
      if (load) begin
         resp_in = new_resp;
         cnt_in = new_cnt;
      end else if (cnt_ff != '0 && !rsp_stall) begin
         resp_in = {8'h00, resp_ff[slcd_pkg::RESP_DEPTH-1:1]};
         cnt_in = cnt_ff - slcd_pkg::RESP_CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff <= 1'b1;
         in_valid_ff <= 1'b0;
         len_ff <= '0;
         led_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            echo_ff <= csr_wr_data;
         end
         in_valid_ff <= in_valid_in;
         len_ff <= len_in;
         led_ff <= led_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      resp_ff <= resp_in;
      if (load && store && len_ff < slcd_pkg::LEN_W'(slcd_pkg::HEAD_DEPTH)) begin
         head_ff[len_ff[slcd_pkg::HEAD_IDX_W-1:0]] <= in_byte_ff;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_tx_byte = resp_ff[0];
   assign rsp_last_byte = (cnt_ff == slcd_pkg::RESP_CNT_W'(1));
   assign rsp_led_on = led_ff;

endmodule
